// File: hw/rtl/pair_copy_diagonal_merge_assert.svh
// Assertion macros shared by the checker of the pair copy diagonal merge block.
`ifndef PAIR_COPY_DIAGONAL_MERGE_ASSERT_SVH
`define PAIR_COPY_DIAGONAL_MERGE_ASSERT_SVH

// Condition in the next cycle, ignored while reset is high.
`define PCDM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition in the cycle after reset was seen high.
`define PCDM_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

// Condition in the same cycle.
`define PCDM_ASSERT_SAME(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/pcdm_pkg.sv
// Package of the pair copy diagonal merge block: widths, defaults and queue word layout.
package pcdm_pkg;

  localparam int KEY_BITS_DEF  = 32;
  localparam int SUM_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int PORT_KEY_BITS = 32;
  localparam int DIAG_BITS     = 16;
  localparam int SCORE_BITS    = 16;
  localparam logic [SCORE_BITS-1:0] SCORE_CAP = 16'hFFFF;

  // Classification the front attaches to every edge it passes on.
  typedef struct packed {
    logic flush;     // a different pair was held: emit it before this edge
    logic open_new;  // this edge opens a new group
    logic eob;       // this edge ends the bucket
  } cmd_flags_t;

  function automatic int cmd_bits(input int key_bits);
    return $bits(cmd_flags_t) + 2 * key_bits + DIAG_BITS + 1 + SCORE_BITS;
  endfunction

endpackage

// File: hw/rtl/pcdm_in_if.sv
// Input channel of the pair copy diagonal merge block: one candidate edge per word.
interface pcdm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [pcdm_pkg::PORT_KEY_BITS-1:0]   rep_key;
  logic [pcdm_pkg::PORT_KEY_BITS-1:0]   member_key;
  logic signed [pcdm_pkg::DIAG_BITS-1:0] diag_in;
  logic                                 strand_in;
  logic [pcdm_pkg::SCORE_BITS-1:0]      kmer_score;
  logic                                 end_of_bucket;

  modport source (
    output valid, rep_key, member_key, diag_in, strand_in, kmer_score, end_of_bucket,
    input  ready
  );
  modport sink (
    input  valid, rep_key, member_key, diag_in, strand_in, kmer_score, end_of_bucket,
    output ready
  );
endinterface

// File: hw/rtl/pcdm_out_if.sv
// Output channel of the pair copy diagonal merge block: one merged edge per word.
interface pcdm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [pcdm_pkg::PORT_KEY_BITS-1:0]   out_rep;
  logic [pcdm_pkg::PORT_KEY_BITS-1:0]   out_member;
  logic signed [pcdm_pkg::DIAG_BITS-1:0] out_diagonal;
  logic                                 out_strand;
  logic [pcdm_pkg::SCORE_BITS-1:0]      merged_score;
  logic                                 last_of_bucket;

  modport source (
    output valid, out_rep, out_member, out_diagonal, out_strand, merged_score, last_of_bucket,
    input  ready
  );
  modport sink (
    input  valid, out_rep, out_member, out_diagonal, out_strand, merged_score, last_of_bucket,
    output ready
  );
endinterface

// File: hw/rtl/pcdm_fifo.sv
// Small command queue between the front and back parts of the merge block.
module pcdm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcdm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/pcdm_front.sv
// Front part: accepts edges, tracks the held pair and classifies each edge for the back part.
module pcdm_front #(
  parameter int KEY_BITS = pcdm_pkg::KEY_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  pcdm_in_if.sink                                 in_edge,
  output logic                                    push,
  output logic [pcdm_pkg::cmd_bits(KEY_BITS)-1:0] push_data,
  input  logic                                    full
);

  logic [KEY_BITS-1:0]  held_rep;
  logic [KEY_BITS-1:0]  held_member;
  logic                 group_open;
  logic [KEY_BITS-1:0]  rep_k;
  logic [KEY_BITS-1:0]  mem_k;
  logic                 accept;
  pcdm_pkg::cmd_flags_t flags;

  assign in_edge.ready = !full;
  assign accept        = in_edge.valid && !full;
  assign push          = accept;

  assign rep_k = KEY_BITS'(in_edge.rep_key);
  assign mem_k = KEY_BITS'(in_edge.member_key);

  always_comb begin
    flags.flush    = group_open && ((rep_k != held_rep) || (mem_k != held_member));
    flags.open_new = !group_open || flags.flush;
    flags.eob      = in_edge.end_of_bucket;
  end

  assign push_data = {flags, rep_k, mem_k, in_edge.diag_in, in_edge.strand_in,
                      in_edge.kmer_score};

  always_ff @(posedge clk) begin
    if (rst) begin
      group_open <= 1'b0;
    end else if (accept) begin
      group_open <= !in_edge.end_of_bucket;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_rep    <= rep_k;
      held_member <= mem_k;
    end
  end

endmodule

// File: hw/rtl/pcdm_back.sv
// Back part: sums runs of equal diagonal, keeps the best run and emits merged edges.
module pcdm_back #(
  parameter int KEY_BITS = pcdm_pkg::KEY_BITS_DEF,
  parameter int SUM_BITS = pcdm_pkg::SUM_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cmd_valid,
  input  logic [pcdm_pkg::cmd_bits(KEY_BITS)-1:0] cmd_data,
  output logic                                    pop,
  pcdm_out_if.source                              out_edge
);

  localparam int DB = pcdm_pkg::DIAG_BITS;
  localparam int SB = pcdm_pkg::SCORE_BITS;

  pcdm_pkg::cmd_flags_t  c_flags;
  logic [KEY_BITS-1:0]   c_rep;
  logic [KEY_BITS-1:0]   c_mem;
  logic signed [DB-1:0]  c_diag;
  logic                  c_strand;
  logic [SB-1:0]         c_score;

  logic [KEY_BITS-1:0]   held_rep;
  logic [KEY_BITS-1:0]   held_member;
  logic signed [DB-1:0]  run_diagonal;
  logic [SUM_BITS-1:0]   run_sum;
  logic [SUM_BITS-1:0]   best_sum;
  logic signed [DB-1:0]  best_diagonal;
  logic                  best_strand;
  logic                  half;

  logic [KEY_BITS-1:0]   held_rep_next;
  logic [KEY_BITS-1:0]   held_member_next;
  logic [SUM_BITS-1:0]   run_sum_next;
  logic [SUM_BITS-1:0]   best_sum_next;
  logic signed [DB-1:0]  best_diagonal_next;
  logic                  best_strand_next;

  logic [SUM_BITS-1:0]   run_base;
  logic [SUM_BITS:0]     sum_wide;
  logic [SUM_BITS-1:0]   run_upd;
  logic                  out_free;
  logic                  emit_old;
  logic                  do_step;

  assign {c_flags, c_rep, c_mem, c_diag, c_strand, c_score} = cmd_data;

  // Saturating run update; a new diagonal restarts the run from zero.
  assign run_base = (c_diag != run_diagonal) ? '0 : run_sum;
  assign sum_wide = {1'b0, run_base} + (SUM_BITS + 1)'(c_score);
  assign run_upd  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

  always_comb begin
    held_rep_next      = held_rep;
    held_member_next   = held_member;
    best_sum_next      = best_sum;
    best_diagonal_next = best_diagonal;
    best_strand_next   = best_strand;
    if (c_flags.open_new) begin
      held_rep_next      = c_rep;
      held_member_next   = c_mem;
      run_sum_next       = SUM_BITS'(c_score);
      best_sum_next      = SUM_BITS'(c_score);
      best_diagonal_next = c_diag;
      best_strand_next   = c_strand;
    end else begin
      run_sum_next = run_upd;
      if (run_upd >= best_sum) begin
        best_sum_next      = run_upd;
        best_diagonal_next = c_diag;
        best_strand_next   = c_strand;
      end
    end
  end

  // A word that flushes the old pair emits it in the same cycle it is taken,
  // unless it also ends the bucket; then a first cycle emits the old pair.
  assign out_free = !out_edge.valid || out_edge.ready;
  assign emit_old = cmd_valid && c_flags.flush && !half && out_free;
  assign do_step  = cmd_valid && (!c_flags.eob || out_free) &&
                    (!c_flags.flush || half || (out_free && !c_flags.eob));
  assign pop      = do_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      half           <= 1'b0;
      out_edge.valid <= 1'b0;
    end else begin
      if (emit_old && !do_step) begin
        half <= 1'b1;
      end else if (do_step) begin
        half <= 1'b0;
      end
      if (emit_old || (do_step && c_flags.eob)) begin
        out_edge.valid <= 1'b1;
      end else if (out_edge.ready) begin
        out_edge.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      held_rep      <= held_rep_next;
      held_member   <= held_member_next;
      run_diagonal  <= c_diag;
      run_sum       <= run_sum_next;
      best_sum      <= best_sum_next;
      best_diagonal <= best_diagonal_next;
      best_strand   <= best_strand_next;
    end
    if (emit_old) begin
      out_edge.out_rep        <= pcdm_pkg::PORT_KEY_BITS'(held_rep);
      out_edge.out_member     <= pcdm_pkg::PORT_KEY_BITS'(held_member);
      out_edge.out_diagonal   <= best_diagonal;
      out_edge.out_strand     <= best_strand;
      out_edge.merged_score   <= (|best_sum[SUM_BITS-1:SB]) ? pcdm_pkg::SCORE_CAP
                                                             : best_sum[SB-1:0];
      out_edge.last_of_bucket <= 1'b0;
    end else if (do_step && c_flags.eob) begin
      out_edge.out_rep        <= pcdm_pkg::PORT_KEY_BITS'(held_rep_next);
      out_edge.out_member     <= pcdm_pkg::PORT_KEY_BITS'(held_member_next);
      out_edge.out_diagonal   <= best_diagonal_next;
      out_edge.out_strand     <= best_strand_next;
      out_edge.merged_score   <= (|best_sum_next[SUM_BITS-1:SB]) ? pcdm_pkg::SCORE_CAP
                                                                  : best_sum_next[SB-1:0];
      out_edge.last_of_bucket <= 1'b1;
    end
  end

endmodule

// File: hw/rtl/pair_copy_diagonal_merge.sv
// Top level of the pair copy diagonal merge block.
// The in_edge channel takes candidate edges sorted by representative key, member
// key, diagonal and strand; the out_edge channel gives one merged edge per pair,
// with the best summed diagonal, its strand and the score capped at 65535.
// Both channels move a word when valid and ready are high at a rising edge of clk.
// Throughput is one input word per cycle while the queue is not full, also across
// pair changes. The front classifies each word in the cycle it is accepted and writes
// it to a four-word queue; the back takes one queued word a cycle while the output is
// free and does the saturating add and best-run compare; merged edges leave through
// the output register. A word that both closes the previous pair and ends the bucket
// gives two merged edges and holds the back for one output load of each.
// When out_edge stalls, the output register holds its word; words that produce no
// merged edge keep flowing, and in_edge.ready drops only once the queue is full.
// Synchronous reset clears the queue, the open-group flag and the output valid;
// in_edge.ready is high in the first cycle after reset.
module pair_copy_diagonal_merge #(
  parameter int KEY_BITS = pcdm_pkg::KEY_BITS_DEF,
  parameter int SUM_BITS = pcdm_pkg::SUM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pcdm_in_if.sink    in_edge,
  pcdm_out_if.source out_edge
);

  localparam int CMD_W = pcdm_pkg::cmd_bits(KEY_BITS);

  logic             push;
  logic [CMD_W-1:0] push_data;
  logic             full;
  logic             pop;
  logic [CMD_W-1:0] pop_data;
  logic             empty;

  pcdm_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_edge   (in_edge),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  pcdm_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (pcdm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  pcdm_back #(
    .KEY_BITS (KEY_BITS),
    .SUM_BITS (SUM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!empty),
    .cmd_data  (pop_data),
    .pop       (pop),
    .out_edge  (out_edge)
  );

endmodule

// File: hw/rtl/pcdm_checker.sv
// Port-level checker of the pair copy diagonal merge block, bound to its top level.
`include "pair_copy_diagonal_merge_assert.svh"

module pcdm_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  `PCDM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "merged word dropped while stalled")
  `PCDM_ASSERT_AFTER_RESET(a_reset_idle, clk, rst, !out_valid, "output valid after reset")
  `PCDM_ASSERT_SAME(a_ready_after_reset, clk, $fell(rst), in_ready, "input not ready after reset")

endmodule

bind pair_copy_diagonal_merge pcdm_checker u_pcdm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_edge.ready),
  .out_valid (out_edge.valid),
  .out_ready (out_edge.ready)
);
